### design/tmtq_pkg.sv
// ----------------------------------------------------------------------------
// tmtq_pkg
// Shared types and constants of the timed multichannel transmit queue.
// ----------------------------------------------------------------------------
package tmtq_pkg;

    localparam int CHANNELS_DEF   = 8;
    localparam int RING_DEPTH_DEF = 64;
    localparam int MAX_RESULTS    = 8;
    localparam int CMDQ_DEPTH     = 2;

    localparam int WORD_W     = 32;
    localparam int ENTRY_W    = 2 * WORD_W;
    localparam int ACTIVE_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_CH_W    = 8;
    localparam int OUT_CH_W   = 3;
    // channel index and visit count carried in a command, sized for 16 channels
    localparam int CMD_CH_W   = 4;
    localparam int VISITS_W   = 5;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_BASE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_LEAD       = 2'd2;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_POLL    = 1'b1;

    typedef enum logic [2:0] {
        KIND_ACCEPTED    = 3'd0,
        KIND_FULL        = 3'd1,
        KIND_BAD_CHANNEL = 3'd2,
        KIND_RELEASED    = 3'd3,
        KIND_NONE_DUE    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_BAD  = 2'd1,
        OP_POLL = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_VISIT  = 2'd1,
        ST_CHECK  = 2'd2,
        ST_FINISH = 2'd3
    } t_back_state;

    typedef struct packed {
        t_op                  op;
        logic [CMD_CH_W-1:0]  ch;
        logic [VISITS_W-1:0]  visits;
        logic [WORD_W-1:0]    word;
        logic [WORD_W-1:0]    stamp;
        logic [WORD_W-1:0]    now;
        logic [WORD_W-1:0]    offset;   // time_base - send_lead
    } t_cmd;

    typedef struct packed {
        t_kind                kind;
        logic [OUT_CH_W-1:0]  channel;
        logic [WORD_W-1:0]    word;
        logic [WORD_W-1:0]    stamp;
        logic                 last;
    } t_result;

endpackage

### design/tmtq_in_if.sv
// ----------------------------------------------------------------------------
// tmtq_in_if
// Input channel: enqueue and poll items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tmtq_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  channel;
    logic [31:0] data_word;
    logic [31:0] release_stamp;
    logic [31:0] now_time;

    modport source (
        output valid, cmd, channel, data_word, release_stamp, now_time,
        input  ready
    );
    modport sink (
        input  valid, cmd, channel, data_word, release_stamp, now_time,
        output ready
    );
endinterface

### design/tmtq_out_if.sv
// ----------------------------------------------------------------------------
// tmtq_out_if
// Output channel: result beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tmtq_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [2:0]  out_channel;
    logic [31:0] out_word;
    logic [31:0] out_stamp;
    logic        last;

    modport source (
        output valid, kind, out_channel, out_word, out_stamp, last,
        input  ready
    );
    modport sink (
        input  valid, kind, out_channel, out_word, out_stamp, last,
        output ready
    );
endinterface

### design/tmtq_ram.sv
// ----------------------------------------------------------------------------
// tmtq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmtq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/tmtq_front.sv
// ----------------------------------------------------------------------------
// tmtq_front
// Accepts input beats, holds the configuration registers and classifies each
// item into a command for the back end.
// ----------------------------------------------------------------------------
module tmtq_front #(
    parameter int CHANNELS = tmtq_pkg::CHANNELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tmtq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tmtq_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    tmtq_in_if.sink                          i_in,
    input  logic                             i_q_full,
    output logic                             o_push,
    output tmtq_pkg::t_cmd                   o_cmd
);

    logic [tmtq_pkg::ACTIVE_W-1:0] r_active;
    logic [tmtq_pkg::WORD_W-1:0]   r_time_base;
    logic [tmtq_pkg::WORD_W-1:0]   r_send_lead;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= tmtq_pkg::ACTIVE_RESET;
            r_time_base <= '0;
            r_send_lead <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tmtq_pkg::CFG_ACTIVE_CHANNELS: begin
                    r_active <= i_cfg_data[tmtq_pkg::ACTIVE_W-1:0];
                end
                tmtq_pkg::CFG_TIME_BASE: begin
                    r_time_base <= i_cfg_data[tmtq_pkg::WORD_W-1:0];
                end
                tmtq_pkg::CFG_SEND_LEAD: begin
                    r_send_lead <= i_cfg_data[tmtq_pkg::WORD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        o_cmd        = '0;
        o_cmd.ch     = i_in.channel[tmtq_pkg::CMD_CH_W-1:0];
        o_cmd.word   = i_in.data_word;
        o_cmd.stamp  = i_in.release_stamp;
        o_cmd.now    = i_in.now_time;
        o_cmd.offset = r_time_base - r_send_lead;
        // visits = min(active_channels, CHANNELS)
        if (32'(r_active) > 32'(CHANNELS)) begin
            o_cmd.visits = tmtq_pkg::VISITS_W'(CHANNELS);
        end else begin
            o_cmd.visits = tmtq_pkg::VISITS_W'(r_active);
        end
        priority if (i_in.cmd == tmtq_pkg::CMD_POLL) begin
            o_cmd.op = tmtq_pkg::OP_POLL;
        end else if (32'(i_in.channel) >= 32'(CHANNELS)) begin
            o_cmd.op = tmtq_pkg::OP_BAD;
        end else begin
            o_cmd.op = tmtq_pkg::OP_ENQ;
        end
    end

endmodule

### design/tmtq_cmd_queue.sv
// ----------------------------------------------------------------------------
// tmtq_cmd_queue
// Short command FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module tmtq_cmd_queue #(
    parameter int DEPTH = tmtq_pkg::CMDQ_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tmtq_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output tmtq_pkg::t_cmd  o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tmtq_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

### design/tmtq_back.sv
// ----------------------------------------------------------------------------
// tmtq_back
// Executes commands: ring pointer bookkeeping, entry store access, the
// channel-by-channel release scan of a poll, and the output register.
// ----------------------------------------------------------------------------
module tmtq_back #(
    parameter int CHANNELS   = tmtq_pkg::CHANNELS_DEF,
    parameter int RING_DEPTH = tmtq_pkg::RING_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  tmtq_pkg::t_cmd  i_q_cmd,
    output logic            o_q_pop,
    tmtq_out_if.source      o_out
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int ADDR_W = CH_W + PTR_W;
    localparam int IDX_W  = $clog2(CHANNELS + 1);
    localparam int N_W    = $clog2(tmtq_pkg::MAX_RESULTS + 1);
    localparam int WW     = tmtq_pkg::WORD_W;

    tmtq_pkg::t_back_state r_state, n_state;

    logic [PTR_W-1:0] r_wp [CHANNELS];
    logic [PTR_W-1:0] r_rp [CHANNELS];

    logic [IDX_W-1:0] r_idx, n_idx;
    logic [N_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0] r_visits;
    logic [WW-1:0]    r_now;
    logic [WW-1:0]    r_offset;

    tmtq_pkg::t_result r_pend, n_pend;
    logic              r_pend_valid, n_pend_valid;
    tmtq_pkg::t_result r_out, out_data;
    logic              r_out_valid;

    logic              out_free;
    logic              out_load;
    logic              poll_start;
    logic              wp_we;
    logic              rp_we;
    logic [CH_W-1:0]   sel_ch;
    logic [PTR_W-1:0]  cur_wp, cur_rp, nxt_wp, nxt_rp;

    logic                          ram_we, ram_re;
    logic [ADDR_W-1:0]             ram_waddr, ram_raddr;
    logic [tmtq_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;
    logic [WW-1:0]                 ent_stamp, ent_word, release_at;
    logic                          due;

    tmtq_ram #(
        .WIDTH (tmtq_pkg::ENTRY_W),
        .DEPTH (2 ** ADDR_W)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // one channel's pointers are looked at per cycle
    assign sel_ch = (r_state == tmtq_pkg::ST_IDLE) ? i_q_cmd.ch[CH_W-1:0]
                                                   : r_idx[CH_W-1:0];
    assign cur_wp = r_wp[sel_ch];
    assign cur_rp = r_rp[sel_ch];
    assign nxt_wp = (cur_wp == PTR_W'(RING_DEPTH - 1)) ? '0 : cur_wp + 1'b1;
    assign nxt_rp = (cur_rp == PTR_W'(RING_DEPTH - 1)) ? '0 : cur_rp + 1'b1;

    assign ent_stamp  = ram_rdata[tmtq_pkg::ENTRY_W-1:WW];
    assign ent_word   = ram_rdata[WW-1:0];
    assign release_at = r_offset + ent_stamp;
    assign due        = (r_now >= release_at);

    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        o_q_pop      = 1'b0;
        poll_start   = 1'b0;
        out_load     = 1'b0;
        out_data     = '0;
        wp_we        = 1'b0;
        rp_we        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = {sel_ch, cur_wp};
        ram_wdata    = {i_q_cmd.stamp, i_q_cmd.word};
        ram_re       = 1'b0;
        ram_raddr    = {sel_ch, cur_rp};

        unique case (r_state)
            tmtq_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_cmd.op)
                        tmtq_pkg::OP_POLL: begin
                            o_q_pop      = 1'b1;
                            poll_start   = 1'b1;
                            n_idx        = '0;
                            n_cnt        = '0;
                            n_pend_valid = 1'b0;
                            n_state      = tmtq_pkg::ST_VISIT;
                        end
                        tmtq_pkg::OP_ENQ: begin
                            if (out_free) begin
                                o_q_pop          = 1'b1;
                                out_load         = 1'b1;
                                out_data.channel = tmtq_pkg::OUT_CH_W'(sel_ch);
                                out_data.last    = 1'b1;
                                if (nxt_wp == cur_rp) begin
                                    out_data.kind = tmtq_pkg::KIND_FULL;
                                end else begin
                                    out_data.kind = tmtq_pkg::KIND_ACCEPTED;
                                    ram_we        = 1'b1;
                                    wp_we         = 1'b1;
                                end
                            end
                        end
                        tmtq_pkg::OP_BAD: begin
                            if (out_free) begin
                                o_q_pop       = 1'b1;
                                out_load      = 1'b1;
                                out_data.kind = tmtq_pkg::KIND_BAD_CHANNEL;
                                out_data.last = 1'b1;
                            end
                        end
                        default: begin
                            o_q_pop = 1'b1;
                        end
                    endcase
                end
            end
            tmtq_pkg::ST_VISIT: begin
                priority if (r_idx >= r_visits ||
                             r_cnt >= N_W'(tmtq_pkg::MAX_RESULTS)) begin
                    n_state = tmtq_pkg::ST_FINISH;
                end else if (cur_wp == cur_rp) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    ram_re  = 1'b1;
                    n_state = tmtq_pkg::ST_CHECK;
                end
            end
            tmtq_pkg::ST_CHECK: begin
                priority if (!due) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = tmtq_pkg::ST_VISIT;
                end else if (r_pend_valid && !out_free) begin
                    // wait for room; read data stays put
                end else begin
                    // the held release is not the last one: send it now
                    if (r_pend_valid) begin
                        out_load = 1'b1;
                        out_data = r_pend;
                    end
                    n_pend.kind    = tmtq_pkg::KIND_RELEASED;
                    n_pend.channel = tmtq_pkg::OUT_CH_W'(r_idx);
                    n_pend.word    = ent_word;
                    n_pend.stamp   = ent_stamp;
                    n_pend.last    = 1'b0;
                    n_pend_valid   = 1'b1;
                    rp_we          = 1'b1;
                    n_cnt          = r_cnt + 1'b1;
                    n_idx          = r_idx + 1'b1;
                    n_state        = tmtq_pkg::ST_VISIT;
                end
            end
            tmtq_pkg::ST_FINISH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_pend_valid) begin
                        out_data = r_pend;
                    end else begin
                        out_data.kind = tmtq_pkg::KIND_NONE_DUE;
                    end
                    out_data.last = 1'b1;
                    n_pend_valid  = 1'b0;
                    n_state       = tmtq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tmtq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmtq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_wp[c] <= '0;
                r_rp[c] <= '0;
            end
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            r_cnt        <= '0;
        end else begin
            if (wp_we) begin
                r_wp[sel_ch] <= nxt_wp;
            end
            if (rp_we) begin
                r_rp[sel_ch] <= nxt_rp;
            end
            r_pend_valid <= n_pend_valid;
            r_idx        <= n_idx;
            r_cnt        <= n_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (out_load) begin
            r_out <= out_data;
        end
        if (poll_start) begin
            r_now    <= i_q_cmd.now;
            r_offset <= i_q_cmd.offset;
            r_visits <= IDX_W'(i_q_cmd.visits);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out.kind;
    assign o_out.out_channel = r_out.channel;
    assign o_out.out_word    = r_out.word;
    assign o_out.out_stamp   = r_out.stamp;
    assign o_out.last        = r_out.last;

endmodule

### design/timed_multichannel_tx_queue_unit.sv
// ----------------------------------------------------------------------------
// timed_multichannel_tx_queue_unit
// Per-channel ring FIFOs of timestamped words, released on poll when due.
// ----------------------------------------------------------------------------
// Enqueue items put a (word, stamp) pair on one channel's ring and return one
// status beat; poll items scan channels 0..min(active_channels,CHANNELS)-1 and
// release each due head entry (now >= time_base - send_lead + stamp, mod 2^32),
// at most eight per poll, ending with last=1 or a single "nothing due" beat.
// The front end takes one item per cycle, while the two-entry command queue is
// not full. The back end handles an enqueue straight from idle; a poll visits
// the channels in turn, with a check state per non-empty channel for the
// registered read of the entry RAM followed by the due compare.
// Results leave through an output register; the back end stalls only when it
// has a beat to emit and that register is still occupied.
// ----------------------------------------------------------------------------
module timed_multichannel_tx_queue_unit #(
    parameter int CHANNELS   = tmtq_pkg::CHANNELS_DEF,
    parameter int RING_DEPTH = tmtq_pkg::RING_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tmtq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tmtq_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    tmtq_in_if.sink                          i_in,
    tmtq_out_if.source                       o_out
);

    tmtq_pkg::t_cmd front_cmd;
    tmtq_pkg::t_cmd q_cmd;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;

    tmtq_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (front_cmd)
    );

    tmtq_cmd_queue #(
        .DEPTH (tmtq_pkg::CMDQ_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    tmtq_back #(
        .CHANNELS   (CHANNELS),
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

### tb/sv/tb_timed_multichannel_tx_queue_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timed_multichannel_tx_queue_unit
// Self-checking bench for the timed multichannel transmit queue. A scoreboard
// tracks per-channel rings and register values, predicts the status and
// release beats of every accepted item, and checks each output beat in order.
// Random gaps and stalls on both sides, several register settings.
// ----------------------------------------------------------------------------
module tb_timed_multichannel_tx_queue_unit;
    import tmtq_pkg::*;

    localparam int CHAN      = CHANNELS_DEF;
    localparam int RING      = RING_DEPTH_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    class tx_queue_scoreboard;
        logic [ACTIVE_W-1:0] active_cnt;
        logic [WORD_W-1:0]   base_time;
        logic [WORD_W-1:0]   lead_time;
        int                  wr_ptr [CHAN];
        int                  rd_ptr [CHAN];
        logic [WORD_W-1:0]   ring_word  [CHAN][RING];
        logic [WORD_W-1:0]   ring_stamp [CHAN][RING];
        t_result             pending_beats [$];
        int                  errors;

        function new();
            active_cnt = ACTIVE_RESET;
            base_time  = '0;
            lead_time  = '0;
            errors     = 0;
            for (int c = 0; c < CHAN; c++) begin
                wr_ptr[c] = 0;
                rd_ptr[c] = 0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ACTIVE_CHANNELS: active_cnt = val[ACTIVE_W-1:0];
                CFG_TIME_BASE:       base_time  = val;
                CFG_SEND_LEAD:       lead_time  = val;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_beats.size();
        endfunction

        function void note_item(logic cmd, logic [IN_CH_W-1:0] ch, logic [WORD_W-1:0] word,
                                logic [WORD_W-1:0] stamp, logic [WORD_W-1:0] now);
            t_result           r;
            int                c;
            int                nxt;
            int                visits;
            int                n;
            logic [WORD_W-1:0] due_at;
            if (cmd == CMD_ENQUEUE) begin
                r = '0;
                r.last = 1'b1;
                if (ch >= CHAN) begin
                    r.kind = KIND_BAD_CHANNEL;
                end else begin
                    c = int'(ch);
                    r.channel = 3'(c);
                    nxt = (wr_ptr[c] + 1) % RING;
                    if (nxt == rd_ptr[c]) begin
                        r.kind = KIND_FULL;
                    end else begin
                        ring_word[c][wr_ptr[c]]  = word;
                        ring_stamp[c][wr_ptr[c]] = stamp;
                        wr_ptr[c] = nxt;
                        r.kind = KIND_ACCEPTED;
                    end
                end
                pending_beats.push_back(r);
            end else begin
                visits = (int'(active_cnt) > CHAN) ? CHAN : int'(active_cnt);
                n = 0;
                for (int i = 0; i < visits && n < MAX_RESULTS; i++) begin
                    if (wr_ptr[i] != rd_ptr[i]) begin
                        due_at = base_time - lead_time + ring_stamp[i][rd_ptr[i]];
                        if (now >= due_at) begin
                            r = '0;
                            r.kind    = KIND_RELEASED;
                            r.channel = 3'(i);
                            r.word    = ring_word[i][rd_ptr[i]];
                            r.stamp   = ring_stamp[i][rd_ptr[i]];
                            pending_beats.push_back(r);
                            rd_ptr[i] = (rd_ptr[i] + 1) % RING;
                            n++;
                        end
                    end
                end
                if (n == 0) begin
                    r = '0;
                    r.kind = KIND_NONE_DUE;
                    r.last = 1'b1;
                    pending_beats.push_back(r);
                end else begin
                    r = pending_beats[pending_beats.size()-1];
                    r.last = 1'b1;
                    pending_beats[pending_beats.size()-1] = r;
                end
            end
        endfunction

        function void check_beat(logic [2:0] kind, logic [OUT_CH_W-1:0] ch,
                                 logic [WORD_W-1:0] word, logic [WORD_W-1:0] stamp,
                                 logic last);
            t_result exp;
            if (pending_beats.size() == 0) begin
                $error("unexpected beat: kind %0d channel %0d word %h", kind, ch, word);
                errors++;
                return;
            end
            exp = pending_beats.pop_front();
            if (kind !== exp.kind) begin
                $error("kind mismatch: expected %0d, actual %0d", exp.kind, kind);
                errors++;
            end
            if (ch !== exp.channel) begin
                $error("out_channel mismatch: expected %0d, actual %0d", exp.channel, ch);
                errors++;
            end
            if (word !== exp.word) begin
                $error("out_word mismatch: expected %h, actual %h", exp.word, word);
                errors++;
            end
            if (stamp !== exp.stamp) begin
                $error("out_stamp mismatch: expected %h, actual %h", exp.stamp, stamp);
                errors++;
            end
            if (last !== exp.last) begin
                $error("last mismatch: expected %0d, actual %0d", exp.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tmtq_in_if  in_if ();
    tmtq_out_if out_if ();

    timed_multichannel_tx_queue_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    tx_queue_scoreboard sb = new();

    bit          tx_gapless = 1'b0;
    bit          rx_gapless = 1'b0;
    logic [31:0] sched_now  = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // output beat is checked before the input beat of the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready)
                sb.check_beat(out_if.kind, out_if.out_channel, out_if.out_word,
                              out_if.out_stamp, out_if.last);
            if (in_if.valid && in_if.ready)
                sb.note_item(in_if.cmd, in_if.channel, in_if.data_word,
                             in_if.release_stamp, in_if.now_time);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timed_multichannel_tx_queue_unit test failed");
        $finish;
    end

    initial begin : rx_side
        int stall;
        out_if.ready = 1'b0;
        forever begin
            stall = rx_gapless ? 0 : $urandom_range(0, 15);
            @(negedge i_clk);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    task automatic send_item(logic cmd, logic [7:0] ch, logic [31:0] word,
                             logic [31:0] stamp, logic [31:0] now);
        int gap;
        gap = tx_gapless ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.cmd           <= cmd;
        in_if.channel       <= ch;
        in_if.data_word     <= word;
        in_if.release_stamp <= stamp;
        in_if.now_time      <= now;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0) @(negedge i_clk);
    endtask

    task automatic program_regs(logic [3:0] act, logic [31:0] base, logic [31:0] lead,
                                bit poke_unused);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        int                    cnt;
        idx[0] = CFG_ACTIVE_CHANNELS;
        val[0] = {28'($urandom_range(0, 32'h0FFF_FFFF)), act};  // upper bits are don't-care
        idx[1] = CFG_TIME_BASE;
        val[1] = base;
        idx[2] = CFG_SEND_LEAD;
        val[2] = lead;
        idx[3] = CFG_UNUSED;
        val[3] = $urandom();
        cnt = poke_unused ? 4 : 3;
        for (int k = 0; k < cnt; k++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            sb.write_reg(idx[k], val[k]);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic rand_item();
        int          sel;
        logic [31:0] offset;
        offset = sb.base_time - sb.lead_time;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            // stamp lands close to the running time so heads come due soon
            send_item(CMD_ENQUEUE, 8'($urandom_range(0, CHAN-1)), $urandom(),
                      sched_now - offset + $urandom_range(0, 300) - 32'd50, $urandom());
        end else if (sel < 50) begin
            send_item(CMD_ENQUEUE, 8'($urandom_range(CHAN, 255)), $urandom(), $urandom(),
                      $urandom());
        end else if (sel < 55) begin
            send_item(CMD_ENQUEUE, 8'($urandom_range(0, CHAN-1)), $urandom(), $urandom(),
                      $urandom());
        end else if (sel < 90) begin
            sched_now = sched_now + $urandom_range(0, 120);
            send_item(CMD_POLL, 8'($urandom()), $urandom(), $urandom(), sched_now);
        end else if (sel < 94) begin
            send_item(CMD_POLL, 8'($urandom()), $urandom(), $urandom(), 32'hFFFF_FFFF);
        end else if (sel < 96) begin
            send_item(CMD_POLL, 8'($urandom()), $urandom(), $urandom(), 32'h0);
        end else begin
            send_item(CMD_POLL, 8'($urandom()), $urandom(), $urandom(), $urandom());
        end
    endtask

    task automatic run_random(int count);
        for (int k = 0; k < count; k++) begin
            if (k % 25 == 0) begin
                tx_gapless = ($urandom_range(0, 3) == 0);
                rx_gapless = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 39) == 0) begin
                idle_input();
                wait_drained();
            end
            rand_item();
        end
    endtask

    task automatic fill_channel(logic [7:0] ch);
        logic [31:0] offset;
        offset = sb.base_time - sb.lead_time;
        // RING + 2 items, three more than the RING - 1 a ring holds, to hit the full status
        repeat (RING + 2)
            send_item(CMD_ENQUEUE, ch, $urandom(),
                      sched_now - offset + $urandom_range(0, 400), $urandom());
    endtask

    initial begin : main
        logic [3:0]  set_act  [7];
        logic [31:0] set_base [7];
        logic [31:0] set_lead [7];
        int          set_len  [7];

        in_if.valid         = 1'b0;
        in_if.cmd           = CMD_ENQUEUE;
        in_if.channel       = '0;
        in_if.data_word     = '0;
        in_if.release_stamp = '0;
        in_if.now_time      = '0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = CFG_ACTIVE_CHANNELS;
        i_cfg_data          = '0;
        i_rst_n             = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset register values
        send_item(CMD_POLL, 8'h00, 32'h0, 32'h0, 32'h0);
        send_item(CMD_ENQUEUE, 8'd0, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_item(CMD_ENQUEUE, 8'd7, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_ENQUEUE, 8'd8, 32'h1234_5678, 32'h0, 32'h0);
        send_item(CMD_ENQUEUE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_POLL, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_item(CMD_POLL, 8'h00, 32'h0, 32'h0, 32'hFFFF_FFFE);
        send_item(CMD_POLL, 8'h00, 32'h0, 32'h0, 32'hFFFF_FFFF);
        for (int c = 0; c < CHAN; c++)
            send_item(CMD_ENQUEUE, 8'(c), 32'h1111_1111 * c, 32'd100 + c, $urandom());
        send_item(CMD_POLL, 8'h00, 32'h0, 32'h0, 32'd99);
        // every channel due at once
        send_item(CMD_POLL, 8'h00, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_item(CMD_ENQUEUE, 8'd1, 32'hA5A5_A5A5, 32'd5, 32'hFFFF_FFFF);
        send_item(CMD_ENQUEUE, 8'd1, 32'h5A5A_5A5A, 32'd6, 32'h0);
        // one pop per channel per poll, head order kept
        send_item(CMD_POLL, 8'h01, 32'h0, 32'h0, 32'd5);
        send_item(CMD_POLL, 8'h01, 32'h0, 32'h0, 32'd5);
        send_item(CMD_POLL, 8'h01, 32'h0, 32'h0, 32'd6);
        idle_input();
        wait_drained();

        set_act[0] = 4'd8;  set_base[0] = 32'h0;         set_lead[0] = 32'h0;
        set_act[1] = 4'd1;  set_base[1] = 32'hFFFF_FFFF; set_lead[1] = 32'h0;
        set_act[2] = 4'd0;  set_base[2] = $urandom();    set_lead[2] = $urandom();
        set_act[3] = 4'd15; set_base[3] = 32'h0;         set_lead[3] = 32'hFFFF_FFFF;
        set_act[4] = 4'd5;  set_base[4] = $urandom();    set_lead[4] = $urandom();
        set_act[5] = 4'd8;  set_base[5] = 32'h8000_0000; set_lead[5] = 32'h7FFF_FFFF;
        set_act[6] = 4'd3;  set_base[6] = 32'hFFFF_FFFF; set_lead[6] = 32'hFFFF_FFFF;
        set_len = '{48, 48, 30, 48, 48, 48, 48};

        for (int p = 0; p < 7; p++) begin
            program_regs(set_act[p], set_base[p], set_lead[p], p == 3);
            if (p == 0)
                fill_channel(8'($urandom_range(0, CHAN-1)));
            run_random(set_len[p]);
            idle_input();
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        if (sb.errors == 0)
            $display("timed_multichannel_tx_queue_unit test passed");
        else
            $display("timed_multichannel_tx_queue_unit test failed");
        $finish;
    end

endmodule

### sim.f
design/tmtq_pkg.sv
design/tmtq_in_if.sv
design/tmtq_out_if.sv
design/tmtq_ram.sv
design/tmtq_front.sv
design/tmtq_cmd_queue.sv
design/tmtq_back.sv
design/timed_multichannel_tx_queue_unit.sv
tb/sv/tb_timed_multichannel_tx_queue_unit.sv
